/* rtl/lfk_pkg.sv */
// Shared constants, widths and the CORDIC arctangent table of the leg kinematics block.
// This package depends on no other file.
package lfk_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int POS_BITS_DEF   = 24;
    localparam int LEN_W          = 16;
    localparam int CFG_IDX_W      = 2;

    // CORDIC datapath: Q.30 values with guard bits
    localparam int CORDIC_STEPS = 24;
    localparam int CX_W         = 34;
    localparam int CZ_W         = 33;
    localparam int TRIG_W       = 18;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COXA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEMUR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIBIA = 2'd2;

    localparam logic [LEN_W-1:0] COXA_RST  = 16'd2048;
    localparam logic [LEN_W-1:0] FEMUR_RST = 16'd6144;
    localparam logic [LEN_W-1:0] TIBIA_RST = 16'd8192;

    // arctangent of 2^-i as a 32-bit binary angle
    function automatic logic signed [CZ_W-1:0] atan_val(input int i);
        logic signed [CZ_W-1:0] v;
        case (i)
            0:  v = 33'sd536870912;
            1:  v = 33'sd316933406;
            2:  v = 33'sd167458907;
            3:  v = 33'sd85004756;
            4:  v = 33'sd42667331;
            5:  v = 33'sd21354465;
            6:  v = 33'sd10679838;
            7:  v = 33'sd5340245;
            8:  v = 33'sd2670163;
            9:  v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41721;
            15: v = 33'sd20860;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2607;
            19: v = 33'sd1303;
            20: v = 33'sd651;
            21: v = 33'sd325;
            22: v = 33'sd162;
            23: v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/leg_forward_kinematics_unit.sv */
// Top level of the three-joint leg forward kinematics pipeline.
// Depends on lfk_pkg, lfk_cordic, lfk_chain and lfk_rotate.
//
// Input channel: in_valid/in_stall carry a tibia-frame point and three joint
// angles; a beat is taken when in_valid is high and in_stall low. Output
// channel: out_valid/out_stall carry the body-frame foot point and the
// saturated flag, one result beat per input beat, in order.
// Configuration: cfg_we, cfg_index, cfg_data write the coxa, femur and tibia
// lengths (indexes 0, 1, 2; others ignored). Write only while idle.
// Pipeline: fold stage, one
// CORDIC step per stage, trig rounding, two chain stages, two rotation stages.
// Throughput: one beat per cycle while the pipeline is not held; the three sine/cosine lanes are fully
// pipelined and each multiplier has its own stage.
// Stall: the whole pipeline holds while out_valid is high and out_stall is
// high; in_stall follows that condition, so no beat is lost or repeated.
// Reset: valid bits clear, lengths return to 0.5, 1.5 and 2.0.
module leg_forward_kinematics_unit
    import lfk_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int POS_BITS   = POS_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [LEN_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [POS_BITS-1:0] local_x,
    input  logic signed [POS_BITS-1:0] local_y,
    input  logic signed [POS_BITS-1:0] local_z,
    input  logic signed [ANGLE_BITS-1:0] coxa_angle,
    input  logic signed [ANGLE_BITS-1:0] femur_angle,
    input  logic signed [ANGLE_BITS-1:0] tibia_angle,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [POS_BITS-1:0] body_x,
    output logic signed [POS_BITS-1:0] body_y,
    output logic signed [POS_BITS-1:0] body_z,
    output logic                       saturated
);

    localparam int TOTAL = CORDIC_LAT + 4;

    logic en;
    logic vld_reg [TOTAL];
    logic [LEN_W-1:0] coxa_reg, femur_reg, tibia_reg;
    logic signed [POS_BITS-1:0] px_reg [CORDIC_LAT];
    logic signed [POS_BITS-1:0] py_reg [CORDIC_LAT];
    logic signed [POS_BITS-1:0] pz_reg [CORDIC_LAT];
    logic [ANGLE_BITS-1:0] aft;
    logic [31:0] tc, tf, tft;
    logic signed [TRIG_W-1:0] sc, cc, sf, cf, sft, cft;
    logic signed [POS_BITS+5:0] r, bz;
    logic signed [POS_BITS-1:0] pz_d;
    logic signed [TRIG_W-1:0] sc_d, cc_d;

    // hold everything while a result waits
    assign en        = !(vld_reg[TOTAL-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[TOTAL-1];

    // length registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coxa_reg  <= COXA_RST;
            femur_reg <= FEMUR_RST;
            tibia_reg <= TIBIA_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COXA:  coxa_reg  <= cfg_data;
                REG_FEMUR: femur_reg <= cfg_data;
                REG_TIBIA: tibia_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < TOTAL; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // point delay matching the trig lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg[0] <= local_x;
            py_reg[0] <= local_y;
            pz_reg[0] <= local_z;
            for (int i = 1; i < CORDIC_LAT; i++)
            begin
                px_reg[i] <= px_reg[i-1];
                py_reg[i] <= py_reg[i-1];
                pz_reg[i] <= pz_reg[i-1];
            end
        end
    end

    // widen to 32-bit binary angles; f+t wraps modulo one turn
    always_comb
    begin
        aft = femur_angle + tibia_angle;
        tc  = {coxa_angle, {(32-ANGLE_BITS){1'b0}}};
        tf  = {femur_angle, {(32-ANGLE_BITS){1'b0}}};
        tft = {aft, {(32-ANGLE_BITS){1'b0}}};
    end

    lfk_cordic u_trig_c (
        .clk(clk), .rst_n(rst_n), .en(en), .angle(tc), .sin_q16(sc), .cos_q16(cc)
    );
    lfk_cordic u_trig_f (
        .clk(clk), .rst_n(rst_n), .en(en), .angle(tf), .sin_q16(sf), .cos_q16(cf)
    );
    lfk_cordic u_trig_ft (
        .clk(clk), .rst_n(rst_n), .en(en), .angle(tft), .sin_q16(sft), .cos_q16(cft)
    );

    lfk_chain #(.POS_BITS(POS_BITS)) u_chain (
        .clk(clk), .en(en),
        .px(px_reg[CORDIC_LAT-1]), .py(py_reg[CORDIC_LAT-1]), .pz(pz_reg[CORDIC_LAT-1]),
        .sc(sc), .cc(cc), .sf(sf), .cf(cf), .sft(sft), .cft(cft),
        .coxa_len(coxa_reg), .femur_len(femur_reg), .tibia_len(tibia_reg),
        .r(r), .bz(bz), .pz_out(pz_d), .sc_out(sc_d), .cc_out(cc_d)
    );

    lfk_rotate #(.POS_BITS(POS_BITS)) u_rotate (
        .clk(clk), .en(en),
        .r(r), .bz(bz), .pz(pz_d), .sc(sc_d), .cc(cc_d),
        .body_x(body_x), .body_y(body_y), .body_z(body_z), .saturated(saturated)
    );

endmodule

/* rtl/lfk_cordic.sv */
// Pipelined CORDIC lane: sine and cosine of a 32-bit binary angle, Q.16, one step per stage.
// Depends on lfk_pkg.
module lfk_cordic
    import lfk_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic [31:0]              angle,
    output logic signed [TRIG_W-1:0] sin_q16,
    output logic signed [TRIG_W-1:0] cos_q16
);

    logic signed [CX_W-1:0] x_reg   [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] y_reg   [CORDIC_STEPS+1];
    logic signed [CZ_W-1:0] z_reg   [CORDIC_STEPS+1];
    logic                   neg_reg [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] sin_reg, cos_reg;

    logic        fold;
    logic [31:0] folded;

    // fold second and third quadrant by pi
    always_comb
    begin
        fold   = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
        folded = fold ? (angle + 32'h8000_0000) : angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            neg_reg[0] <= fold;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= CZ_W'($signed(folded));
        end
    end

    // rotation steps
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CX_W-1:0] dx, dy;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;
        // y feeds x and x feeds y
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                neg_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CZ_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - atan_val(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + atan_val(i);
                end
            end
        end
    end

    // round Q.30 to Q.16 and undo the fold
    logic signed [CX_W-1:0] xr, yr;
    logic signed [TRIG_W-1:0] xc, yc;
    always_comb
    begin
        xr = (x_reg[CORDIC_STEPS] + CX_W'(8192)) >>> 14;
        yr = (y_reg[CORDIC_STEPS] + CX_W'(8192)) >>> 14;
        xc = xr[TRIG_W-1:0];
        yc = yr[TRIG_W-1:0];
        if (neg_reg[CORDIC_STEPS])
        begin
            xc = -xc;
            yc = -yc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= xc;
            sin_reg <= yc;
        end
    end

    assign sin_q16 = sin_reg;
    assign cos_q16 = cos_reg;

endmodule

/* rtl/lfk_chain.sv */
// Planar femur-tibia chain: products, then sums rounded to Q.12 (two stages).
// Depends on lfk_pkg.
module lfk_chain
    import lfk_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [POS_BITS-1:0] px,
    input  logic signed [POS_BITS-1:0] py,
    input  logic signed [POS_BITS-1:0] pz,
    input  logic signed [TRIG_W-1:0]   sc,
    input  logic signed [TRIG_W-1:0]   cc,
    input  logic signed [TRIG_W-1:0]   sf,
    input  logic signed [TRIG_W-1:0]   cf,
    input  logic signed [TRIG_W-1:0]   sft,
    input  logic signed [TRIG_W-1:0]   cft,
    input  logic [LEN_W-1:0]           coxa_len,
    input  logic [LEN_W-1:0]           femur_len,
    input  logic [LEN_W-1:0]           tibia_len,
    output logic signed [POS_BITS+5:0] r,
    output logic signed [POS_BITS+5:0] bz,
    output logic signed [POS_BITS-1:0] pz_out,
    output logic signed [TRIG_W-1:0]   sc_out,
    output logic signed [TRIG_W-1:0]   cc_out
);

    localparam int SW = POS_BITS + 22;
    localparam int RW = SW - 16;

    logic signed [SW-1:0] xc_reg, ys_reg, xs_reg, yc_reg;
    logic signed [SW-1:0] tc_reg, ts_reg, fc_reg, fs_reg, co_reg;
    logic signed [POS_BITS-1:0] pz1_reg, pz2_reg;
    logic signed [TRIG_W-1:0]   sc1_reg, cc1_reg, sc2_reg, cc2_reg;
    logic signed [RW-1:0] r_reg, bz_reg;
    logic signed [SW-1:0] r_sum, bz_sum;

    // stage one: all products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xc_reg  <= SW'(px * cft);
            ys_reg  <= SW'(py * sft);
            xs_reg  <= SW'(px * sft);
            yc_reg  <= SW'(py * cft);
            tc_reg  <= SW'($signed({1'b0, tibia_len}) * cft);
            ts_reg  <= SW'($signed({1'b0, tibia_len}) * sft);
            fc_reg  <= SW'($signed({1'b0, femur_len}) * cf);
            fs_reg  <= SW'($signed({1'b0, femur_len}) * sf);
            co_reg  <= SW'($signed({1'b0, coxa_len, 16'd0}));
            pz1_reg <= pz;
            sc1_reg <= sc;
            cc1_reg <= cc;
        end
    end

    // stage two: sums, rounded to Q.12
    always_comb
    begin
        r_sum  = xc_reg - ys_reg + tc_reg + fc_reg + co_reg + SW'(32'sd32768);
        bz_sum = xs_reg + yc_reg + ts_reg + fs_reg + SW'(32'sd32768);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_sum[SW-1:16];
            bz_reg  <= bz_sum[SW-1:16];
            pz2_reg <= pz1_reg;
            sc2_reg <= sc1_reg;
            cc2_reg <= cc1_reg;
        end
    end

    assign r      = r_reg;
    assign bz     = bz_reg;
    assign pz_out = pz2_reg;
    assign sc_out = sc2_reg;
    assign cc_out = cc2_reg;

endmodule

/* rtl/lfk_rotate.sv */
// Coxa rotation, rounding and saturation into the output register (two stages).
// Depends on lfk_pkg.
module lfk_rotate
    import lfk_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [POS_BITS+5:0] r,
    input  logic signed [POS_BITS+5:0] bz,
    input  logic signed [POS_BITS-1:0] pz,
    input  logic signed [TRIG_W-1:0]   sc,
    input  logic signed [TRIG_W-1:0]   cc,
    output logic signed [POS_BITS-1:0] body_x,
    output logic signed [POS_BITS-1:0] body_y,
    output logic signed [POS_BITS-1:0] body_z,
    output logic                       saturated
);

    localparam int RW = POS_BITS + 6;
    localparam int PW = RW + TRIG_W + 1;
    localparam logic signed [PW-1:0] HI = (PW'(1) <<< (POS_BITS - 1)) - PW'(1);
    localparam logic signed [PW-1:0] LO = -(PW'(1) <<< (POS_BITS - 1));

    logic signed [PW-1:0] rc_reg, zs_reg, rs_reg, zc_reg, bz_reg;
    logic signed [PW-1:0] sx, sy, vx, vy;
    logic signed [POS_BITS-1:0] bx_reg, by_reg, bzo_reg;
    logic                       sat_reg;
    logic signed [POS_BITS-1:0] cx, cy, cz;
    logic                       ox, oy, oz;

    // stage one: rotation products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rc_reg <= PW'(r * cc);
            zs_reg <= PW'(pz * sc);
            rs_reg <= PW'(r * sc);
            zc_reg <= PW'(pz * cc);
            bz_reg <= PW'(bz);
        end
    end

    // stage two: sum, round, clip
    always_comb
    begin
        sx = rc_reg + zs_reg + PW'(32'sd32768);
        sy = rs_reg - zc_reg + PW'(32'sd32768);
        vx = sx >>> 16;
        vy = sy >>> 16;
        ox = (vx > HI) || (vx < LO);
        oy = (vy > HI) || (vy < LO);
        oz = (bz_reg > HI) || (bz_reg < LO);
        cx = (vx > HI) ? HI[POS_BITS-1:0] : ((vx < LO) ? LO[POS_BITS-1:0] : vx[POS_BITS-1:0]);
        cy = (vy > HI) ? HI[POS_BITS-1:0] : ((vy < LO) ? LO[POS_BITS-1:0] : vy[POS_BITS-1:0]);
        cz = (bz_reg > HI) ? HI[POS_BITS-1:0]
           : ((bz_reg < LO) ? LO[POS_BITS-1:0] : bz_reg[POS_BITS-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bx_reg  <= cx;
            by_reg  <= cy;
            bzo_reg <= cz;
            sat_reg <= ox || oy || oz;
        end
    end

    assign body_x    = bx_reg;
    assign body_y    = by_reg;
    assign body_z    = bzo_reg;
    assign saturated = sat_reg;

endmodule
